FILE: rtl/itr_pkg.sv
// shared types, widths and constants of the integer to roman numeral encoder
// the numeral table lives here; used by the interfaces, the core and the top level
`default_nettype none

package itr_pkg;

  localparam int VALUE_W  = 12;
  localparam int SYM_W    = 7;
  localparam int WEIGHT_W = 10;
  localparam int IDX_W    = 4;

  localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

  // ascii letters
  localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYM_W-1:0] CH_I    = 7'h49;
  localparam logic [SYM_W-1:0] CH_V    = 7'h56;
  localparam logic [SYM_W-1:0] CH_X    = 7'h58;
  localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYM_W-1:0] CH_C    = 7'h43;
  localparam logic [SYM_W-1:0] CH_D    = 7'h44;
  localparam logic [SYM_W-1:0] CH_M    = 7'h4D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PAIR,
    ST_ERR
  } itr_state_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             range_error;
  } itr_word_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SYM_W-1:0]    lead;
    logic [SYM_W-1:0]    tail;
    logic                pair;
  } itr_entry_t;

  // greedy numeral table, largest weight first
  function automatic itr_entry_t itr_entry(input logic [IDX_W-1:0] idx);
    itr_entry_t e;
    case (idx)
      4'd0:    e = '{weight: 10'd1000, lead: CH_M, tail: CH_NONE, pair: 1'b0};
      4'd1:    e = '{weight: 10'd900,  lead: CH_C, tail: CH_M,    pair: 1'b1};
      4'd2:    e = '{weight: 10'd500,  lead: CH_D, tail: CH_NONE, pair: 1'b0};
      4'd3:    e = '{weight: 10'd400,  lead: CH_C, tail: CH_D,    pair: 1'b1};
      4'd4:    e = '{weight: 10'd100,  lead: CH_C, tail: CH_NONE, pair: 1'b0};
      4'd5:    e = '{weight: 10'd90,   lead: CH_X, tail: CH_C,    pair: 1'b1};
      4'd6:    e = '{weight: 10'd50,   lead: CH_L, tail: CH_NONE, pair: 1'b0};
      4'd7:    e = '{weight: 10'd40,   lead: CH_X, tail: CH_L,    pair: 1'b1};
      4'd8:    e = '{weight: 10'd10,   lead: CH_X, tail: CH_NONE, pair: 1'b0};
      4'd9:    e = '{weight: 10'd9,    lead: CH_I, tail: CH_X,    pair: 1'b1};
      4'd10:   e = '{weight: 10'd5,    lead: CH_V, tail: CH_NONE, pair: 1'b0};
      4'd11:   e = '{weight: 10'd4,    lead: CH_I, tail: CH_V,    pair: 1'b1};
      default: e = '{weight: 10'd1,    lead: CH_I, tail: CH_NONE, pair: 1'b0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itr_if.sv
// valid/ready channel interfaces of the roman numeral encoder
// depends on itr_pkg for the payload widths
`default_nettype none

interface itr_in_if;
  import itr_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itr_out_if;
  import itr_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             range_error;

  modport source (output valid, output symbol, output last, output range_error, input ready);
  modport sink   (input valid, input symbol, input last, input range_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/itr_core.sv
// sequencer and shared compare/subtract unit that walks the numeral table
// depends on itr_pkg; emits at most one letter word per cycle, none on a skipped entry
`default_nettype none

module itr_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [itr_pkg::VALUE_W-1:0] value_i,
  input  wire logic                       stall_i,
  output logic                            idle_o,
  output logic                            word_valid_o,
  output itr_pkg::itr_word_t              word_o
);
  import itr_pkg::*;

  itr_state_e         state_q, state_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  itr_entry_t         ent;
  logic               ge;
  logic [VALUE_W-1:0] diff;

  // the one shared unit: compare and subtract against the current table entry
  assign ent  = itr_entry(idx_q);
  assign ge   = rem_q >= {{(VALUE_W-WEIGHT_W){1'b0}}, ent.weight};
  assign diff = rem_q - {{(VALUE_W-WEIGHT_W){1'b0}}, ent.weight};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    idx_q <= idx_d;
  end

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    idle_o       = 1'b0;
    word_valid_o = 1'b0;
    word_o       = '{symbol: CH_NONE, last: 1'b0, range_error: 1'b0};
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          rem_d = value_i;
          idx_d = '0;
          if (value_i == '0 || value_i > MAX_VALID) begin
            state_d = ST_ERR;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (ge) begin
          word_valid_o = 1'b1;
          word_o.symbol = ent.lead;
          word_o.last   = !ent.pair && (diff == '0);
          if (!stall_i) begin
            rem_d = diff;
            if (ent.pair) begin
              state_d = ST_PAIR;
            end else if (diff == '0) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_PAIR: begin
        // second letter of a subtractive pair; the entry is never used twice
        word_valid_o = 1'b1;
        word_o.symbol = ent.tail;
        word_o.last   = (rem_q == '0);
        if (!stall_i) begin
          idx_d = idx_q + 1'b1;
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_ERR: begin
        word_valid_o = 1'b1;
        word_o = '{symbol: CH_NONE, last: 1'b1, range_error: 1'b1};
        if (!stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/integer_to_roman_encoder.sv
// top level of the integer to roman numeral encoder: input handshake and output register
// depends on itr_pkg, itr_if and itr_core
// after an accept the sequencer loads the value, then walks the table; each letter it finds
//   goes out through the output register (13-entry greedy table, one compare/subtract unit,
//   up to 12 skips before a letter); an out-of-range value yields a single error word;
//   a new value is taken only after the sequencer has emitted the last word of the previous one
// input is ready only when idle; reset clears the sequencer state and the output valid flag
`default_nettype none

module integer_to_roman_encoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itr_in_if.sink     in_i,
  itr_out_if.source  out_o
);
  import itr_pkg::*;

  logic      core_idle;
  logic      core_valid;
  itr_word_t core_word;
  logic      stall;

  logic      out_valid_q, out_valid_d;
  itr_word_t out_word_q, out_word_d;

  assign stall      = out_valid_q && !out_o.ready;
  assign in_i.ready = core_idle;

  itr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_i.valid),
    .value_i      (in_i.value),
    .stall_i      (stall),
    .idle_o       (core_idle),
    .word_valid_o (core_valid),
    .word_o       (core_word)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (!stall) begin
      out_valid_d = core_valid;
      out_word_d  = core_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.symbol      = out_word_q.symbol;
  assign out_o.last        = out_word_q.last;
  assign out_o.range_error = out_word_q.range_error;

endmodule

`default_nettype wire

FILE: rtl/itr_chk.sv
// port-level checks for the roman numeral encoder, bound to the top level
// depends on itr_pkg for the letter codes
`default_nettype none

module itr_chk (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [itr_pkg::SYM_W-1:0] out_symbol_i,
  input wire logic                     out_last_i,
  input wire logic                     out_range_error_i
);
  import itr_pkg::*;

  // error word is a lone terminal word with no letter
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_range_error_i |-> out_last_i && out_symbol_i == CH_NONE)
    else $error("error word not terminal or carries a letter");

  // a normal word always carries a numeral letter
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_range_error_i |->
      out_symbol_i == CH_I || out_symbol_i == CH_V || out_symbol_i == CH_X ||
      out_symbol_i == CH_L || out_symbol_i == CH_C || out_symbol_i == CH_D ||
      out_symbol_i == CH_M)
    else $error("letter word without a numeral letter");

  // one value at a time: input closes right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a numeral is in progress");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_symbol_i) && $stable(out_last_i) &&
      $stable(out_range_error_i))
    else $error("stalled output word changed");

endmodule

bind integer_to_roman_encoder itr_chk u_itr_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_symbol_i      (out_o.symbol),
  .out_last_i        (out_o.last),
  .out_range_error_i (out_o.range_error)
);

`default_nettype wire

FILE: tb/sv/integer_to_roman_encoder_test.sv
// self-checking testbench of the integer to roman numeral encoder: directed table, then random
// values under three idling mixes; depends on itr_pkg, itr_if and the integer_to_roman_encoder rtl
`timescale 1ns / 100ps

module integer_to_roman_encoder_test;
  import itr_pkg::*;

  localparam int DIR_N       = 25;
  localparam int RAND_N      = 42;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;

  itr_in_if  in_ch ();
  itr_out_if out_ch ();

  integer_to_roman_encoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // letters still owed by the encoder, oldest first
  itr_word_t expected_words [$];

  int errors        = 0;
  int values_sent   = 0;
  int out_of_range  = 0;
  int letters_seen  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;

  // empty text: spelled by the predictor; "!": range error word
  logic [VALUE_W-1:0] dir_value [DIR_N] = '{
    12'd0, 12'd1, 12'd4, 12'd9, 12'd3999, 12'd3888, 12'd4000, 12'd4095, 12'd1000,
    12'd3000, 12'd5, 12'd8, 12'd14, 12'd40, 12'd44, 12'd90, 12'd99, 12'd400,
    12'd444, 12'd900, 12'd999, 12'd1994, 12'd2048, 12'd2730, 12'd1365
  };
  string dir_text [DIR_N] = '{
    "!", "I", "IV", "IX", "MMMCMXCIX", "MMMDCCCLXXXVIII", "!", "!", "M",
    "MMM", "V", "VIII", "", "", "", "", "", "",
    "", "", "", "", "", "", ""
  };

  // append one owed word at the tail of the queue
  function automatic void book_word(input itr_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
    logic [SYM_W-1:0] letters [0:15];
    logic [SYM_W-1:0] one;
    logic [SYM_W-1:0] five;
    logic [SYM_W-1:0] ten;
    itr_word_t w;
    int cnt;
    int d;
    cnt = 0;
    if (v == '0 || v > MAX_VALID) begin
      w.symbol      = CH_NONE;
      w.last        = 1'b1;
      w.range_error = 1'b1;
      book_word(w);
      return;
    end
    for (int i = 0; i < v / 1000; i++) begin
      letters[cnt] = CH_M;
      cnt = cnt + 1;
    end
    for (int place = 2; place >= 0; place--) begin
      case (place)
        2: begin
          one = CH_C; five = CH_D; ten = CH_M; d = (v / 100) % 10;
        end
        1: begin
          one = CH_X; five = CH_L; ten = CH_C; d = (v / 10) % 10;
        end
        default: begin
          one = CH_I; five = CH_V; ten = CH_X; d = v % 10;
        end
      endcase
      if (d == 9 || d == 4) begin
        letters[cnt]     = one;
        letters[cnt + 1] = (d == 9) ? ten : five;
        cnt = cnt + 2;
      end else begin
        if (d >= 5) begin
          letters[cnt] = five;
          cnt = cnt + 1;
          d = d - 5;
        end
        for (int k = 0; k < d; k++) begin
          letters[cnt] = one;
          cnt = cnt + 1;
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      w.symbol      = letters[i];
      w.last        = (i == cnt - 1);
      w.range_error = 1'b0;
      book_word(w);
    end
  endfunction

  function automatic void push_spelled(input string s);
    itr_word_t w;
    byte ch;
    if (s == "!") begin
      w.symbol      = CH_NONE;
      w.last        = 1'b1;
      w.range_error = 1'b1;
      book_word(w);
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      ch            = s[i];
      w.symbol      = ch[SYM_W-1:0];
      w.last        = (i == s.len() - 1);
      w.range_error = 1'b0;
      book_word(w);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return VALUE_W'($urandom_range(3999, 1));
    if (roll < 80) return VALUE_W'($urandom_range(4095, 4000));
    if (roll < 85) return '0;
    return VALUE_W'($urandom);
  endfunction

  // offer one value, hold it until taken, then book its letters
  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= VALUE_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (text == "") spell_numeral(v);
    else push_spelled(text);
    values_sent = values_sent + 1;
    if (v == '0 || v > MAX_VALID) out_of_range = out_of_range + 1;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random back-pressure, or a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    itr_word_t got;
    itr_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.symbol      = out_ch.symbol;
      got.last        = out_ch.last;
      got.range_error = out_ch.range_error;
      letters_seen    = letters_seen + 1;
      if (expected_words.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected word symbol %h last %b range_error %b",
                 $time, got.symbol, got.last, got.range_error);
      end else begin
        want = expected_words.pop_front();
        if (got.symbol !== want.symbol || got.last !== want.last ||
            got.range_error !== want.range_error) begin
          errors = errors + 1;
          $display("%0t: expected %h/%b/%b, got %h/%b/%b (symbol/last/range_error)",
                   $time, want.symbol, want.last, want.range_error,
                   got.symbol, got.last, got.range_error);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
             expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 81;
    for (int i = 0; i < DIR_N; i++) send_value(dir_value[i], dir_text[i]);
    for (int i = 0; i < RAND_N; i++) begin
      // long receiver stall while values keep coming
      if (i == 20) hold_request = 1'b1;
      send_value(pick_value(), "");
    end

    send_idle_pct = 81;
    recv_idle_pct = 12;
    for (int i = 0; i < RAND_N; i++) send_value(pick_value(), "");

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RAND_N; i++) send_value(pick_value(), "");

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("converted %0d values (%0d out of range) and checked %0d letter words",
             values_sent, out_of_range, letters_seen);
    $display("idling mixes: sender-light, receiver-light, none; one %0d-cycle output stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/itr_pkg.sv
rtl/itr_if.sv
rtl/itr_core.sv
rtl/integer_to_roman_encoder.sv
rtl/itr_chk.sv
tb/sv/integer_to_roman_encoder_test.sv
